/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file rtlex_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication under an active-low reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* design/rtlex_pkg.sv */
// ----------------------------------------------------------------------------
// rtlex_pkg
// Types and character constants for the header token lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package rtlex_pkg;

	typedef enum logic [7:0] {
		MODE_BETWEEN = 8'b0000_0001,
		MODE_WORD    = 8'b0000_0010,
		MODE_QUOTED  = 8'b0000_0100,
		MODE_QESC    = 8'b0000_1000,
		MODE_COMMENT = 8'b0001_0000,
		MODE_CESC    = 8'b0010_0000,
		MODE_CQUOTE  = 8'b0100_0000,
		MODE_CQESC   = 8'b1000_0000
	} lex_mode_t;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_COMMENT = 2'd1;
	localparam logic [1:0] ERR_QUOTE   = 2'd2;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       token_start;
		logic       prev_token_done;
		logic       token_done;
		logic       stray_special;
		logic [1:0] end_error;
		logic       depth_overflow;
	} lex_res_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} lex_item_t;

	function automatic logic is_special(input logic [7:0] c);
		return c inside {8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A,
			8'h5C, 8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h20};
	endfunction

endpackage

`default_nettype wire

/* design/rtlex_in_reg.sv */
// ----------------------------------------------------------------------------
// rtlex_in_reg
// Input register stage: holds one byte until the lexer consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rtlex_in_reg (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  rtlex_pkg::lex_item_t   in_item,
	input  wire                    take,
	output logic                   item_valid_s1,
	output rtlex_pkg::lex_item_t   item_s1
);
	import rtlex_pkg::*;

	assign in_ready = !item_valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

/* design/rtlex_core.sv */
// ----------------------------------------------------------------------------
// rtlex_core
// Lexer state (mode, comment depth) and per-byte result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module rtlex_core #(
	parameter int unsigned MAX_NEST = 255
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    step,
	input  rtlex_pkg::lex_item_t   item,
	output rtlex_pkg::lex_res_t    res
);
	import rtlex_pkg::*;

	localparam int unsigned LIMIT_INT = (MAX_NEST > 255) ? 255 : ((MAX_NEST < 1) ? 1 : MAX_NEST);
	localparam logic [7:0] DEPTH_LIMIT = 8'(LIMIT_INT);

	lex_mode_t  mode_q, mode_d;
	logic [7:0] depth_q, depth_d;
	logic       between;
	logic [7:0] c;

	assign c = item.in_byte;

	always_comb begin
		res     = '0;
		mode_d  = mode_q;
		depth_d = depth_q;
		between = 1'b0;

		case (mode_q)
			MODE_BETWEEN: begin
				between = 1'b1;
			end
			MODE_WORD: begin
				if (is_special(c)) begin
					res.prev_token_done = 1'b1;
					mode_d              = MODE_BETWEEN;
					between             = 1'b1;
				end else begin
					res.out_byte  = c;
					res.out_valid = 1'b1;
				end
			end
			MODE_QUOTED: begin
				if (c == CH_DQUOTE) begin
					res.token_done = 1'b1;
					mode_d         = MODE_BETWEEN;
				end else if (c == CH_BSLASH) begin
					mode_d = MODE_QESC;
				end else begin
					res.out_byte  = c;
					res.out_valid = 1'b1;
				end
			end
			MODE_QESC: begin
				res.out_byte  = c;
				res.out_valid = 1'b1;
				mode_d        = MODE_QUOTED;
			end
			MODE_COMMENT: begin
				if (c == CH_LPAREN) begin
					if (depth_q >= DEPTH_LIMIT) begin
						depth_d            = DEPTH_LIMIT;
						res.depth_overflow = 1'b1;
					end else begin
						depth_d = depth_q + 8'd1;
					end
				end else if (c == CH_RPAREN) begin
					if (depth_q <= 8'd1) begin
						depth_d = 8'd0;
						mode_d  = MODE_BETWEEN;
					end else begin
						depth_d = depth_q - 8'd1;
					end
				end else if (c == CH_BSLASH) begin
					mode_d = MODE_CESC;
				end else if (c == CH_DQUOTE) begin
					mode_d = MODE_CQUOTE;
				end
			end
			MODE_CESC: begin
				mode_d = MODE_COMMENT;
			end
			MODE_CQUOTE: begin
				if (c == CH_DQUOTE) begin
					mode_d = MODE_COMMENT;
				end else if (c == CH_BSLASH) begin
					mode_d = MODE_CQESC;
				end
			end
			MODE_CQESC: begin
				mode_d = MODE_CQUOTE;
			end
			default: begin
				mode_d = MODE_BETWEEN;
			end
		endcase

		if (between) begin
			if (c == CH_SPACE) begin
				mode_d = MODE_BETWEEN;
			end else if (c == CH_LPAREN) begin
				mode_d  = MODE_COMMENT;
				depth_d = 8'd1;
			end else if (c == CH_DQUOTE) begin
				res.token_start = 1'b1;
				mode_d          = MODE_QUOTED;
			end else if (is_special(c)) begin
				res.stray_special = 1'b1;
				mode_d            = MODE_BETWEEN;
			end else begin
				res.token_start = 1'b1;
				res.out_byte    = c;
				res.out_valid   = 1'b1;
				mode_d          = MODE_WORD;
			end
		end

		// close any open token at the end of the string
		if (item.last_byte) begin
			case (mode_d)
				MODE_WORD: begin
					res.token_done = 1'b1;
				end
				MODE_QUOTED, MODE_QESC: begin
					res.token_done = 1'b1;
					res.end_error  = ERR_QUOTE;
				end
				MODE_COMMENT, MODE_CESC, MODE_CQUOTE, MODE_CQESC: begin
					res.end_error = ERR_COMMENT;
				end
				default: begin
					res.end_error = ERR_NONE;
				end
			endcase
			mode_d  = MODE_BETWEEN;
			depth_d = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_BETWEEN;
			depth_q <= 8'd0;
		end else if (step) begin
			mode_q  <= mode_d;
			depth_q <= depth_d;
		end
	end

endmodule

`default_nettype wire

/* design/rtlex_out_reg.sv */
// ----------------------------------------------------------------------------
// rtlex_out_reg
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rtlex_out_reg (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    load,
	input  rtlex_pkg::lex_res_t    res_d,
	output logic                   can_load,
	output logic                   res_valid_q,
	input  wire                    res_ready,
	output rtlex_pkg::lex_res_t    res_q
);
	import rtlex_pkg::*;

	assign can_load = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (can_load) begin
			res_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			res_q <= res_d;
		end
	end

endmodule

`default_nettype wire

/* design/rfc822_token_lexer_top.sv */
// ----------------------------------------------------------------------------
// rfc822_token_lexer_top
// Header-string tokenizer: one result transfer for every input byte.
//
// Slave channel (s_*): one character per transfer in s_tdata, s_tlast marks
// the final byte of the string. Master channel (m_*): one result per byte,
// in input order; m_tuser flags a token data byte in m_tdata[7:0].
// Path: a byte taken at the slave port waits in the input register, and its
// result is loaded into the result register and shown on m_* once it can load.
// Throughput: one byte per cycle while m_tready stays high; the mode/depth
// update in rtlex_core, registered on each step, sets the rate, and the input
// and result registers let a new byte enter while the previous result waits.
// Reset: both registers empty, lexer between tokens with comment depth zero.
// The lexer also returns to that state after every byte marked s_tlast.
// Stall: while m_tready is low the result holds; at most one more byte is taken
// into the input register, then s_tready drops until the result moves.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc822_token_lexer_top #(
	parameter int unsigned MAX_NEST = 255
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,  // [7:0] in_byte
	input  wire         s_tlast,  // last_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,  // [7:0] out_byte, [8] token_start, [9] prev_token_done,
	                              // [10] token_done, [11] stray_special,
	                              // [13:12] end_error, [14] depth_overflow, [15] zero
	output logic        m_tuser   // out_valid
);
	import rtlex_pkg::*;

	lex_item_t in_item;
	lex_item_t item_s1;
	logic      item_valid_s1;
	logic      can_load;
	logic      step;
	lex_res_t  res_d;
	lex_res_t  res_q;

	assign in_item.in_byte   = s_tdata;
	assign in_item.last_byte = s_tlast;
	assign step              = item_valid_s1 && can_load;

	rtlex_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_item       (in_item),
		.take          (can_load),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	rtlex_core #(
		.MAX_NEST (MAX_NEST)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.res    (res_d)
	);

	rtlex_out_reg u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (item_valid_s1),
		.res_d       (res_d),
		.can_load    (can_load),
		.res_valid_q (m_tvalid),
		.res_ready   (m_tready),
		.res_q       (res_q)
	);

	assign m_tuser = res_q.out_valid;
	assign m_tdata = {1'b0, res_q.depth_overflow, res_q.end_error, res_q.stray_special,
		res_q.token_done, res_q.prev_token_done, res_q.token_start, res_q.out_byte};

endmodule

`default_nettype wire

/* design/rtlex_checker.sv */
// ----------------------------------------------------------------------------
// rtlex_checker
// Port-level checks on the lexer's result channel and s_tready, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rtlex_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [15:0] m_tdata,
	input wire        m_tuser
);

	`ASSERT_NEXT(a_hold_stalled, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`ASSERT_IMPLIES(a_byte_zero_idle, clk, arst_n, m_tvalid && !m_tuser,
		m_tdata[7:0] == 8'h00)
	`ASSERT_IMPLIES(a_end_error_code, clk, arst_n, m_tvalid, m_tdata[13:12] != 2'b11)
	`ASSERT_IMPLIES(a_flags_exclusive, clk, arst_n, m_tvalid,
		!(m_tdata[11] && (m_tdata[8] || m_tuser)) && !(m_tdata[9] && m_tuser))
	`ASSERT_IMPLIES(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready)

endmodule

bind rfc822_token_lexer_top rtlex_checker u_rtlex_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
